FILE: rtl/fgmn_pkg.sv
// Package: shared types and constants for the functional graph meeting node block.
package fgmn_pkg;

  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int DIST_W    = IDX_W;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] node_index;
    logic [IDX_W-1:0] successor;
    logic             has_successor;
    logic [IDX_W-1:0] start_a;
    logic [IDX_W-1:0] start_b;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] meeting_node;
    logic             none_found;
  } out_t;

  typedef struct packed {
    logic             edge_ok;
    logic [IDX_W-1:0] succ;
  } succ_entry_t;

  typedef struct packed {
    logic              reached;
    logic [DIST_W-1:0] hops;
  } dist_entry_t;

endpackage

FILE: rtl/functional_graph_meeting_node.sv
// Top level: successor table with a sequenced two-walk closest meeting node query.
// Load transaction: successor table written at the accepting edge.
// Query: a clear pass over the nodes in use, then walk A with one request/response state pair per
//   node plus one pair for a closing revisit, then walk B with one pair per step; result strobe follows.
// A new request is taken only when idle; busy is high while a query runs.
// Synchronous active-low reset: node_count 1024, idle, no strobe; table contents undefined.
module functional_graph_meeting_node
  import fgmn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CLR  = 6'b000010,
    ST_AREQ = 6'b000100,
    ST_ARSP = 6'b001000,
    ST_BREQ = 6'b010000,
    ST_BRSP = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  node_count_r;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_last;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [DIST_W-1:0] d_r, d_nxt;
  logic [IDX_W-1:0]  start_b_r, start_b_nxt;
  logic              found_r, found_nxt;
  logic [DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic [IDX_W-1:0]  best_node_r, best_node_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  succ_entry_t succ_mem [MAX_NODES];
  dist_entry_t dist_mem [MAX_NODES];
  succ_entry_t succ_rd_r;
  dist_entry_t dist_rd_r;
  logic        succ_we;
  logic        dist_we;
  dist_entry_t dist_wdata;
  logic [DIST_W-1:0] m_val;
  logic        go_next;
  logic        accept;

  assign n_eff     = (node_count_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_r;
  assign n_last    = n_eff - CNT_W'(1);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign succ_we = accept && (in_data.req_type == REQ_LOAD);

  always_ff @(posedge clk) begin
    if (succ_we) begin
      succ_mem[in_data.node_index] <= '{edge_ok: in_data.has_successor,
                                        succ: in_data.successor};
    end
    succ_rd_r <= succ_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[cur_r] <= dist_wdata;
    end
    dist_rd_r <= dist_mem[cur_r];
  end

  assign m_val   = (dist_rd_r.hops > d_r) ? dist_rd_r.hops : d_r;
  assign go_next = succ_rd_r.edge_ok && ({1'b0, succ_rd_r.succ} < n_eff);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    d_nxt         = d_r;
    start_b_nxt   = start_b_r;
    found_nxt     = found_r;
    best_dist_nxt = best_dist_r;
    best_node_nxt = best_node_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    dist_we       = 1'b0;
    dist_wdata    = '{reached: 1'b0, hops: '0};
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.req_type == REQ_QUERY)) begin
          cur_nxt     = in_data.start_a;
          start_b_nxt = in_data.start_b;
          found_nxt   = 1'b0;
          d_nxt       = '0;
          if (n_eff == '0) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{meeting_node: '0, none_found: 1'b1};
          end else begin
            cur_nxt   = '0;
            state_nxt = ST_CLR;
          end
          best_node_nxt = in_data.start_a;
        end
      end
      ST_CLR: begin
        dist_we = 1'b1;
        cur_nxt = cur_r + IDX_W'(1);
        if ({1'b0, cur_r} == n_last) begin
          cur_nxt = best_node_r;
          if ({1'b0, best_node_r} < n_eff) begin
            state_nxt = ST_AREQ;
          end else begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{meeting_node: '0, none_found: 1'b1};
          end
        end
      end
      ST_AREQ: begin
        state_nxt = ST_ARSP;
      end
      ST_ARSP: begin
        if (!dist_rd_r.reached) begin
          dist_we    = 1'b1;
          dist_wdata = '{reached: 1'b1, hops: d_r};
        end
        if (!dist_rd_r.reached && go_next) begin
          cur_nxt   = succ_rd_r.succ;
          d_nxt     = d_r + DIST_W'(1);
          state_nxt = ST_AREQ;
        end else if ({1'b0, start_b_r} < n_eff) begin
          cur_nxt   = start_b_r;
          d_nxt     = '0;
          state_nxt = ST_BREQ;
        end else begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{meeting_node: '0, none_found: 1'b1};
        end
      end
      ST_BREQ: begin
        state_nxt = ST_BRSP;
      end
      ST_BRSP: begin
        if (dist_rd_r.reached && (!found_r || (m_val < best_dist_r) ||
            ((m_val == best_dist_r) && (cur_r < best_node_r)))) begin
          found_nxt     = 1'b1;
          best_dist_nxt = m_val;
          best_node_nxt = cur_r;
        end
        if (go_next && (d_r != n_last[DIST_W-1:0])) begin
          cur_nxt   = succ_rd_r.succ;
          d_nxt     = d_r + DIST_W'(1);
          state_nxt = ST_BREQ;
        end else begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{meeting_node: found_nxt ? best_node_nxt : '0,
                            none_found: !found_nxt};
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= CNT_W'(MAX_NODES);
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    d_r         <= d_nxt;
    start_b_r   <= start_b_nxt;
    best_dist_r <= best_dist_nxt;
    best_node_r <= best_node_nxt;
    out_data_r  <= out_data_nxt;
  end

  // result strobe only in an idle cycle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result strobe while busy");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.none_found) |-> (out_data_r.meeting_node == '0))
    else $error("meeting node not zero with none_found");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.none_found) |-> ({1'b0, out_data_r.meeting_node} < n_eff))
    else $error("meeting node outside nodes in use");

  a_clr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> ({1'b0, cur_r} < n_eff))
    else $error("clear pass index past node count");

endmodule

FILE: sim/tb_top.sv
// Testbench for functional_graph_meeting_node: random loads and queries against a predictor.
`timescale 1ns / 1ps

module tb_top
  import fgmn_pkg::*;
();

  localparam int SETTLE = 16;
  localparam int SPAN_CAP = 12;

  class meeting_checker;
    succ_entry_t succ_table[MAX_NODES];
    bit loaded[MAX_NODES];
    int unsigned node_count;
    out_t expected_meetings[$];
    int errors;
    int loads;
    int queries;
    int misses;

    function new();
      node_count = MAX_NODES;
      errors = 0;
      loads = 0;
      queries = 0;
      misses = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function int unsigned nodes_in_use();
      return (node_count > MAX_NODES) ? MAX_NODES : node_count;
    endfunction

    // true when a walk from s only reads entries that were loaded
    function bit walk_is_loaded(logic [IDX_W-1:0] s);
      int unsigned n;
      int unsigned cur;
      bit seen[MAX_NODES];
      n = nodes_in_use();
      cur = 32'(s);
      foreach (seen[i]) seen[i] = 1'b0;
      while (cur < n && !seen[cur]) begin
        if (!loaded[cur]) return 1'b0;
        seen[cur] = 1'b1;
        if (!succ_table[cur].edge_ok) break;
        cur = 32'(succ_table[cur].succ);
      end
      return 1'b1;
    endfunction

    function out_t closest_meeting(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
      int unsigned n;
      int unsigned cur;
      int unsigned d;
      int unsigned m;
      int unsigned best;
      bit hit[2][MAX_NODES];
      int unsigned hop_count[2][MAX_NODES];
      bit found;
      out_t r;
      n = nodes_in_use();
      found = 1'b0;
      best = 0;
      r = '0;
      for (int w = 0; w < 2; w++) begin
        for (int i = 0; i < MAX_NODES; i++) begin
          hit[w][i] = 1'b0;
          hop_count[w][i] = 0;
        end
        cur = (w == 0) ? 32'(a) : 32'(b);
        d = 0;
        while (cur < n && !hit[w][cur]) begin
          hit[w][cur] = 1'b1;
          hop_count[w][cur] = d;
          if (!succ_table[cur].edge_ok) break;
          cur = 32'(succ_table[cur].succ);
          d++;
        end
      end
      for (int i = 0; i < n; i++) begin
        if (hit[0][i] && hit[1][i]) begin
          m = (hop_count[0][i] > hop_count[1][i]) ? hop_count[0][i] : hop_count[1][i];
          if (!found || m < best) begin
            found = 1'b1;
            best = m;
            r.meeting_node = IDX_W'(i);
          end
        end
      end
      r.none_found = !found;
      return r;
    endfunction

    function void note_request(in_t it);
      out_t want;
      if (it.req_type == REQ_LOAD) begin
        succ_table[it.node_index].edge_ok = it.has_successor;
        succ_table[it.node_index].succ = it.successor;
        loaded[it.node_index] = 1'b1;
        loads++;
      end else begin
        want = closest_meeting(it.start_a, it.start_b);
        expected_meetings = {expected_meetings, want};
        queries++;
      end
    endfunction

    function void check_meeting(out_t got);
      out_t want;
      if (expected_meetings.size() == 0) begin
        $display("%0t: result with no pending query: meeting_node=%0d none_found=%0b",
                 $time, got.meeting_node, got.none_found);
        errors++;
        return;
      end
      want = expected_meetings.pop_front();
      if (got.meeting_node !== want.meeting_node) begin
        $display("%0t: meeting_node mismatch: expected %0d actual %0d",
                 $time, want.meeting_node, got.meeting_node);
        errors++;
      end
      if (got.none_found !== want.none_found) begin
        $display("%0t: none_found mismatch: expected %0b actual %0b",
                 $time, want.none_found, got.none_found);
        errors++;
      end
      if (want.none_found) misses++;
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_t              in_data;
  logic             out_valid;
  out_t             out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  meeting_checker chk = new();
  int burst_left;
  bit steady;

  functional_graph_meeting_node uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) chk.check_meeting(out_data);
  end

  function automatic in_t rand_fill();
    logic [63:0] r;
    in_t x;
    r = {$urandom, $urandom};
    x = r[$bits(in_t)-1:0];
    return x;
  endfunction

  function automatic in_t mk_load(int unsigned idx, int unsigned succ, bit has);
    in_t x;
    x = rand_fill();
    x.req_type = REQ_LOAD;
    x.node_index = IDX_W'(idx);
    x.successor = IDX_W'(succ);
    x.has_successor = has;
    return x;
  endfunction

  function automatic in_t mk_query(int unsigned a, int unsigned b);
    in_t x;
    x = rand_fill();
    x.req_type = REQ_QUERY;
    x.start_a = IDX_W'(a);
    x.start_b = IDX_W'(b);
    return x;
  endfunction

  function automatic logic [IDX_W-1:0] pick_node(int unsigned span);
    if ($urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, span - 1));
    return IDX_W'($urandom_range(0, MAX_NODES - 1));
  endfunction

  // queries only where both walks stay on loaded entries, else a load
  function automatic in_t random_request(int unsigned span);
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    int unsigned idx;
    int unsigned r;
    if ($urandom_range(0, 1)) begin
      for (int t = 0; t < 32; t++) begin
        a = pick_node(span);
        b = pick_node(span);
        if (chk.walk_is_loaded(a) && chk.walk_is_loaded(b)) return mk_query(a, b);
      end
    end
    idx = ($urandom_range(0, 9) < 8) ? $urandom_range(0, span - 1)
                                     : $urandom_range(0, MAX_NODES - 1);
    r = $urandom_range(0, 19);
    if (r < 14) return mk_load(idx, $urandom_range(0, span - 1), 1'b1);
    if (r < 17) return mk_load(idx, $urandom_range(0, MAX_NODES - 1), 1'b1);
    return mk_load(idx, $urandom_range(0, MAX_NODES - 1), 1'b0);
  endfunction

  task automatic issue(in_t it);
    start = 1'b1;
    in_data = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    chk.note_request(it);
    @(negedge clk);
  endtask

  task automatic send(in_t it);
    int gap;
    issue(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (chk.expected_meetings.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_node_count(int unsigned v);
    cfg_valid = 1'b1;
    cfg_data = CNT_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    chk.node_count = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic prefill(int unsigned span);
    int unsigned r;
    for (int unsigned i = 0; i < span; i++) begin
      r = $urandom_range(0, 9);
      if (r < 8) send(mk_load(i, $urandom_range(0, span - 1), 1'b1));
      else if (r == 8) send(mk_load(i, $urandom_range(0, MAX_NODES - 1), 1'b0));
      else send(mk_load(i, MAX_NODES - 1, 1'b1));
    end
  endtask

  initial begin
    int unsigned phase_count[10] = '{1, 0, 2047, 2, 1024, 5, 16, 37, 700, 9};
    int phase_items[10] = '{8, 5, 8, 8, 8, 10, 12, 12, 8, 11};
    int unsigned n;
    int unsigned span;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    burst_left = 0;
    steady = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: cycle, tail into cycle, dead end, self loop, exit past count, ties
    write_node_count(8);
    send(mk_load(0, 1, 1'b1));
    send(mk_load(1, 2, 1'b1));
    send(mk_load(2, 0, 1'b1));
    send(mk_load(3, 2, 1'b1));
    send(mk_load(4, 5, 1'b1));
    send(mk_load(5, MAX_NODES - 1, 1'b0));
    send(mk_load(6, 6, 1'b1));
    send(mk_load(7, MAX_NODES - 1, 1'b1));
    send(mk_load(MAX_NODES - 1, 0, 1'b1));
    send(mk_query(0, 0));
    send(mk_query(3, 0));
    send(mk_query(0, 3));
    send(mk_query(4, 5));
    send(mk_query(4, 6));
    send(mk_query(6, 6));
    send(mk_query(7, 7));
    send(mk_query(7, 3));
    send(mk_query(MAX_NODES - 1, 0));
    send(mk_query(0, MAX_NODES - 1));
    send(mk_query(MAX_NODES - 1, MAX_NODES - 1));
    send(mk_query(3, 4));
    send(mk_query(1, 2));
    send(mk_query(2, 1));

    for (int p = 0; p < 10; p++) begin
      drain();
      write_node_count(phase_count[p]);
      steady = (p % 4 == 1);
      n = chk.nodes_in_use();
      span = (n == 0) ? 1 : ((n < SPAN_CAP) ? n : SPAN_CAP);
      if (n > 0) prefill(span);
      for (int k = 0; k < phase_items[p]; k++) send(random_request(span));
    end

    drain();
    $display("Covered %0d successor loads and %0d meeting queries (%0d with no meeting node)",
             chk.loads, chk.queries, chk.misses);
    $display("over 11 node_count settings from 0 to 2047; %0d mismatches", chk.errors);
    if (chk.errors == 0 && chk.expected_meetings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("FAILURE");
    $finish;
  end

endmodule
